@@ src/mrf_pkg.sv @@
package mrf_pkg;

	// Input request: one item of a Modbus request stream
	typedef struct packed {
		logic [7:0] unit_id;
		logic [7:0] func_code;
		logic [7:0] payload_len;
		logic [7:0] payload_byte;
		logic       payload_valid;
		logic       first;
		logic       last;
	} req_t;

	// Output: one byte of the outgoing frame
	typedef struct packed {
		logic [7:0] frame_byte;
		logic       frame_end;
		logic       run_last;
	} res_t;

	// Byte slots of one request, in send order
	localparam int SLOT_NUM = 11;
	localparam int SLOT_W   = $clog2(SLOT_NUM);

	typedef enum logic [SLOT_W-1:0] {
		SLOT_TID_HI,
		SLOT_TID_LO,
		SLOT_PROTO_HI,
		SLOT_PROTO_LO,
		SLOT_LEN_HI,
		SLOT_LEN_LO,
		SLOT_UID,
		SLOT_FC,
		SLOT_PAY,
		SLOT_CRC_LO,
		SLOT_CRC_HI
	} slot_t;

	localparam logic [15:0] CRC_INIT  = 16'hFFFF;
	localparam logic [15:0] CRC_POLY  = 16'hA001;
	localparam logic [15:0] LEN_EXTRA = 16'd2;
	localparam logic [7:0]  PROTO_ID  = 8'h00;

	// CRC-16, reflected, one byte folded in
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
		logic [15:0] c;
		c = crc ^ {8'h00, data};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

@@ src/mrf_out_reg.sv @@
module mrf_out_reg (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  mrf_pkg::res_t  din,
	output logic           out_free,
	output logic           valid,
	input  logic           ready,
	output mrf_pkg::res_t  dout
);

	logic          valid_q;
	mrf_pkg::res_t res_q;

	// Register can take a new byte when empty or being drained
	assign out_free = !valid_q || ready;
	assign valid    = valid_q;
	assign dout     = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= din;
		end
	end

endmodule

@@ src/mrf_seq.sv @@
module mrf_seq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           link_mode,
	input  logic           req_valid,
	output logic           req_ready,
	input  mrf_pkg::req_t  req,
	input  logic           out_free,
	output logic           emit,
	output mrf_pkg::res_t  emit_res
);

	// Held request
	logic          req_vld_s1;
	mrf_pkg::req_t req_s1;

	// Frame state
	logic                          in_frame_q;
	logic [15:0]                   tid_q;
	logic [15:0]                   crc_q;
	logic [mrf_pkg::SLOT_NUM-1:0]  done_q;

	logic                          active;
	logic [mrf_pkg::SLOT_NUM-1:0]  mask;
	logic [mrf_pkg::SLOT_NUM-1:0]  remain;
	logic [mrf_pkg::SLOT_NUM-1:0]  cur_onehot;
	logic [mrf_pkg::SLOT_W-1:0]    cur_idx;
	mrf_pkg::slot_t                cur;
	logic                          any_left;
	logic                          one_left;
	logic                          complete;
	logic [15:0]                   len;
	logic [7:0]                    byte_sel;
	logic                          feeds_crc;
	logic [15:0]                   crc_base;
	logic [15:0]                   crc_next;

	// Which slots this request sends
	always_comb begin
		active = req_s1.first || in_frame_q;
		mask   = '0;
		mask[mrf_pkg::SLOT_TID_HI]   = active && req_s1.first && link_mode;
		mask[mrf_pkg::SLOT_TID_LO]   = active && req_s1.first && link_mode;
		mask[mrf_pkg::SLOT_PROTO_HI] = active && req_s1.first && link_mode;
		mask[mrf_pkg::SLOT_PROTO_LO] = active && req_s1.first && link_mode;
		mask[mrf_pkg::SLOT_LEN_HI]   = active && req_s1.first && link_mode;
		mask[mrf_pkg::SLOT_LEN_LO]   = active && req_s1.first && link_mode;
		mask[mrf_pkg::SLOT_UID]      = active && req_s1.first;
		mask[mrf_pkg::SLOT_FC]       = active && req_s1.first;
		mask[mrf_pkg::SLOT_PAY]      = active && req_s1.payload_valid;
		mask[mrf_pkg::SLOT_CRC_LO]   = active && req_s1.last && !link_mode;
		mask[mrf_pkg::SLOT_CRC_HI]   = active && req_s1.last && !link_mode;
		remain = mask & ~done_q;
	end

	// Lowest pending slot goes next
	always_comb begin
		cur_idx = '0;
		for (int i = mrf_pkg::SLOT_NUM - 1; i >= 0; i--) begin
			if (remain[i]) begin
				cur_idx = mrf_pkg::SLOT_W'(i);
			end
		end
	end

	assign cur        = mrf_pkg::slot_t'(cur_idx);
	assign cur_onehot = mrf_pkg::SLOT_NUM'(1) << cur_idx;
	assign any_left   = |remain;
	assign one_left   = (remain & (remain - mrf_pkg::SLOT_NUM'(1))) == '0;

	// Handshake: one byte per cycle while the output register has room
	assign emit      = req_vld_s1 && any_left && out_free;
	assign complete  = req_vld_s1 && (!any_left || (one_left && out_free));
	assign req_ready = !req_vld_s1 || complete;

	assign len = {8'h00, req_s1.payload_len} + mrf_pkg::LEN_EXTRA;

	// Byte select
	always_comb begin
		case (cur)
			mrf_pkg::SLOT_TID_HI:   byte_sel = tid_q[15:8];
			mrf_pkg::SLOT_TID_LO:   byte_sel = tid_q[7:0];
			mrf_pkg::SLOT_PROTO_HI: byte_sel = mrf_pkg::PROTO_ID;
			mrf_pkg::SLOT_PROTO_LO: byte_sel = mrf_pkg::PROTO_ID;
			mrf_pkg::SLOT_LEN_HI:   byte_sel = len[15:8];
			mrf_pkg::SLOT_LEN_LO:   byte_sel = len[7:0];
			mrf_pkg::SLOT_UID:      byte_sel = req_s1.unit_id;
			mrf_pkg::SLOT_FC:       byte_sel = req_s1.func_code;
			mrf_pkg::SLOT_PAY:      byte_sel = req_s1.payload_byte;
			mrf_pkg::SLOT_CRC_LO:   byte_sel = crc_q[7:0];
			mrf_pkg::SLOT_CRC_HI:   byte_sel = crc_q[15:8];
			default:                byte_sel = '0;
		endcase
	end

	// CRC covers unit id, function code and payload; restarts at unit id
	assign feeds_crc = (cur == mrf_pkg::SLOT_UID) || (cur == mrf_pkg::SLOT_FC) ||
		(cur == mrf_pkg::SLOT_PAY);
	assign crc_base  = (cur == mrf_pkg::SLOT_UID) ? mrf_pkg::CRC_INIT : crc_q;
	assign crc_next  = mrf_pkg::crc_byte(crc_base, byte_sel);

	always_comb begin
		emit_res.frame_byte = byte_sel;
		emit_res.run_last   = one_left;
		emit_res.frame_end  = one_left && req_s1.last;
	end

	// Request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_vld_s1 <= 1'b0;
		end else if (req_ready) begin
			req_vld_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req;
		end
	end

	// Sent-slot tracking and frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q     <= '0;
			crc_q      <= mrf_pkg::CRC_INIT;
			in_frame_q <= 1'b0;
			tid_q      <= '0;
		end else begin
			if (complete) begin
				done_q <= '0;
			end else if (emit) begin
				done_q <= done_q | cur_onehot;
			end
			if (emit && feeds_crc) begin
				crc_q <= crc_next;
			end
			if (complete && active) begin
				if (req_s1.first) begin
					in_frame_q <= 1'b1;
				end
				if (req_s1.last) begin
					in_frame_q <= 1'b0;
					if (link_mode) begin
						tid_q <= tid_q + 16'd1;
					end
				end
			end
		end
	end

endmodule

@@ src/modbus_request_framer.sv @@
// Modbus request framer (RTU with CRC-16, or TCP with MBAP header).
// Request channel: req_valid/req_ready carry one req item. The item with
// first set brings unit id, function code and payload length; any item may
// carry one payload byte; last closes the request.
// Frame channel: frm_valid/frm_ready carry one frame byte per transfer, with
// frame_end on the final byte of a frame and run_last on the last byte caused
// by a given request.
// cfg_we/cfg_wdata write link_mode (0 RTU, 1 TCP); write it only while idle.
// An accepted request waits in the request register while its bytes go on
// into the frame register, which the sequencer fills at one byte per cycle
// while it has room. A request holds the request register until its last
// byte is sent, so plain payload items run at one per cycle unless the
// receiver stalls; TCP first items add the MBAP header, RTU last items the CRC.
// Reset clears link_mode, the transaction id and the frame state and loads
// the CRC with 0xFFFF. If the receiver stalls, the frame register holds its
// byte, the sequencer stops, and req_ready drops once the request register
// is busy.
module modbus_request_framer (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic           cfg_wdata,
	input  logic           req_valid,
	output logic           req_ready,
	input  mrf_pkg::req_t  req,
	output logic           frm_valid,
	input  logic           frm_ready,
	output mrf_pkg::res_t  frm
);

	logic          link_mode_q;
	logic          out_free;
	logic          emit;
	mrf_pkg::res_t emit_res;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_mode_q <= 1'b0;
		end else if (cfg_we) begin
			link_mode_q <= cfg_wdata;
		end
	end

	mrf_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.link_mode (link_mode_q),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.out_free  (out_free),
		.emit      (emit),
		.emit_res  (emit_res)
	);

	mrf_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (emit),
		.din      (emit_res),
		.out_free (out_free),
		.valid    (frm_valid),
		.ready    (frm_ready),
		.dout     (frm)
	);

`ifndef SYNTHESIS
	a_end_is_run_last: assert property (@(posedge clk) disable iff (!arst_n)
		frm_valid && frm.frame_end |-> frm.run_last)
		else $error("frame_end without run_last");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (!frm_valid || frm_ready))
		else $error("byte emitted into a stalled frame register");

	a_drain_empties: assert property (@(posedge clk) disable iff (!arst_n)
		frm_valid && frm_ready && !emit |=> !frm_valid)
		else $error("frame register valid without a new byte");
`endif

endmodule
